// ----- sv/rtoc_pkg.sv -----
// ----------------------------------------------------------------------------
// rtoc_pkg - shared types and constants of the RGB565 text overlay compositor
// Command and register codes, configuration and cell position structs, and
// the fixed screen, grid and font geometry.
// ----------------------------------------------------------------------------
package rtoc_pkg;

	// Screen and grid geometry
	localparam int SCREEN_WIDTH   = 480;
	localparam int SCREEN_HEIGHT  = 272;
	localparam int MAX_GRID_CELLS = 32;

	// Font store: 128 glyphs of 8 words, two glyph lines per word
	localparam int FONT_DEPTH = 1024;
	localparam int FONT_AW    = 10;

	// Field widths
	localparam int CODE_W      = 7;
	localparam int CFG_DATA_W  = 12;
	localparam int CFG_INDEX_W = 3;
	localparam int COORD_W     = 9;
	localparam int INDEX_W     = 10;
	localparam int DATA_W      = 16;
	localparam int ARGB_W      = 32;

	localparam logic [12:0] SCREEN_W_LIM = 13'(SCREEN_WIDTH);
	localparam logic [12:0] SCREEN_H_LIM = 13'(SCREEN_HEIGHT);
	localparam logic [5:0]  GRID_MAX     = 6'(MAX_GRID_CELLS);

	localparam logic [7:0]        ALPHA_OPAQUE = 8'hFF;
	localparam logic [ARGB_W-1:0] ARGB_WHITE   = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		CMD_PIXEL    = 2'd0,
		CMD_TEXT_WR  = 2'd1,
		CMD_FONT_WR  = 2'd2
	} cmd_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_OVERLAY_ENABLE = 3'd0,
		REG_ORIGIN_X       = 3'd1,
		REG_ORIGIN_Y       = 3'd2,
		REG_GRID_COLUMNS   = 3'd3,
		REG_GRID_ROWS      = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic               overlay_enable;
		logic signed [11:0] origin_x;
		logic signed [11:0] origin_y;
		logic [5:0]         grid_columns;
		logic [5:0]         grid_rows;
	} cfg_t;

	// Where a pixel lands in the character grid
	typedef struct packed {
		logic         hit;
		logic [9:0]   tidx;
		logic [2:0]   gx;
		logic [3:0]   gy;
	} cell_pos_t;

endpackage

// ----- sv/rtoc_ram.sv -----
// ----------------------------------------------------------------------------
// rtoc_ram - generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered and holds while
// the read enable is low.
// ----------------------------------------------------------------------------
module rtoc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- sv/rtoc_cell_map.sv -----
// ----------------------------------------------------------------------------
// rtoc_cell_map - reverse map of a screen pixel onto the character grid
// Gives the overlay hit flag, the text store index and the glyph position.
// ----------------------------------------------------------------------------
module rtoc_cell_map (
	input  logic [rtoc_pkg::COORD_W-1:0] pixel_x,
	input  logic [rtoc_pkg::COORD_W-1:0] pixel_y,
	input  rtoc_pkg::cfg_t               cfg,
	output rtoc_pkg::cell_pos_t          pos
);

	logic [5:0]         cols;
	logic [5:0]         rows;
	logic signed [12:0] dx;
	logic signed [12:0] dy;
	logic [8:0]         col_span;
	logic [9:0]         row_span;
	logic               in_x;
	logic               in_y;
	logic               on_screen;
	logic [10:0]        row_base;
	logic [10:0]        tidx_full;

	// Saturate the grid size
	assign cols = (cfg.grid_columns > rtoc_pkg::GRID_MAX) ? rtoc_pkg::GRID_MAX : cfg.grid_columns;
	assign rows = (cfg.grid_rows > rtoc_pkg::GRID_MAX) ? rtoc_pkg::GRID_MAX : cfg.grid_rows;

	assign dx = $signed({4'b0, pixel_x}) - $signed({cfg.origin_x[11], cfg.origin_x});
	assign dy = $signed({4'b0, pixel_y}) - $signed({cfg.origin_y[11], cfg.origin_y});

	assign col_span = {cols, 3'b000};
	assign row_span = {rows, 4'b0000};

	assign in_x = !dx[12] && (dx[11:0] < {3'b000, col_span});
	assign in_y = !dy[12] && (dy[11:0] < {2'b00, row_span});

	assign on_screen = ({4'b0, pixel_x} < rtoc_pkg::SCREEN_W_LIM)
		&& ({4'b0, pixel_y} < rtoc_pkg::SCREEN_H_LIM);

	assign row_base  = {6'b0, dy[8:4]} * {5'b0, cols};
	assign tidx_full = row_base + {6'b0, dx[7:3]};

	always_comb begin
		pos.hit  = cfg.overlay_enable && on_screen && in_x && in_y;
		pos.tidx = tidx_full[9:0];
		pos.gx   = dx[2:0];
		pos.gy   = dy[3:0];
	end

endmodule

// ----- sv/rgb565_text_overlay_compositor.sv -----
// ----------------------------------------------------------------------------
// rgb565_text_overlay_compositor - RGB565 to ARGB8888 with character overlay
// Expands each pixel request to opaque ARGB8888 and forces it white where the
// glyph bit of the 8x16 character cell under it is set. Store requests load
// the text and font memories.
// ----------------------------------------------------------------------------
// Pipeline: an accepted pixel request passes the text memory read, the font
//   memory read and the output register on its way to the port.
// Throughput: one request per clock while out_stall is low; each memory takes
//   one access per cycle. Reset: configuration clears to zero; a clearing pass
//   then zeroes both memories, one entry per cycle, with in_stall held high.
// ----------------------------------------------------------------------------
module rgb565_text_overlay_compositor #(
	parameter int TEXT_DEPTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,

	// Configuration writes
	input  logic                              cfg_write,
	input  logic [rtoc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [rtoc_pkg::CFG_DATA_W-1:0]   cfg_data,

	// Request channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        command,
	input  logic [rtoc_pkg::COORD_W-1:0]      pixel_x,
	input  logic [rtoc_pkg::COORD_W-1:0]      pixel_y,
	input  logic [rtoc_pkg::DATA_W-1:0]       pixel_rgb565,
	input  logic [rtoc_pkg::INDEX_W-1:0]      store_index,
	input  logic [rtoc_pkg::DATA_W-1:0]       store_data,

	// Result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [rtoc_pkg::ARGB_W-1:0]       argb_pixel
);

	localparam int          TEXT_AW    = $clog2(TEXT_DEPTH);
	localparam logic [10:0] TEXT_LIMIT = 11'(TEXT_DEPTH);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	rtoc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				rtoc_pkg::REG_OVERLAY_ENABLE: cfg_q.overlay_enable <= cfg_data[0];
				rtoc_pkg::REG_ORIGIN_X:       cfg_q.origin_x       <= $signed(cfg_data);
				rtoc_pkg::REG_ORIGIN_Y:       cfg_q.origin_y       <= $signed(cfg_data);
				rtoc_pkg::REG_GRID_COLUMNS:   cfg_q.grid_columns   <= cfg_data[5:0];
				rtoc_pkg::REG_GRID_ROWS:      cfg_q.grid_rows      <= cfg_data[5:0];
				default: ;  // unmapped index: drop the write
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Clearing pass after reset: sweep both memories with zero
	// ------------------------------------------------------------------
	logic                         clear_busy_q;
	logic [rtoc_pkg::FONT_AW-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_busy_q <= 1'b1;
			clr_q        <= '0;
		end else if (clear_busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == rtoc_pkg::FONT_AW'(rtoc_pkg::FONT_DEPTH - 1)) begin
				clear_busy_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Flow control: each stage advances when the next one is free or moving
	// ------------------------------------------------------------------
	logic valid_s1;
	logic valid_s2;
	logic out_free;
	logic adv2;
	logic adv1;
	logic in_acc;
	logic move1;
	logic move2;

	assign out_free = !out_valid || !out_stall;
	assign adv2     = !valid_s2 || out_free;
	assign adv1     = !valid_s1 || adv2;
	// Hold off requests while the clearing pass runs
	assign in_stall = clear_busy_q || !adv1;
	assign in_acc   = in_valid && !in_stall;
	assign move1    = valid_s1 && adv2;
	assign move2    = valid_s2 && out_free;

	// ------------------------------------------------------------------
	// Stage 0: map pixel onto grid, access text memory
	// ------------------------------------------------------------------
	rtoc_pkg::cell_pos_t pos;
	logic                tidx_ok;
	logic [23:0]         rgb888;

	rtoc_cell_map u_cell_map (
		.pixel_x (pixel_x),
		.pixel_y (pixel_y),
		.cfg     (cfg_q),
		.pos     (pos)
	);

	// Text past the store depth reads as character code zero
	assign tidx_ok = {1'b0, pos.tidx} < TEXT_LIMIT;

	// Replicate the top bits of each channel into the low bits
	assign rgb888 = {pixel_rgb565[15:11], pixel_rgb565[15:13],
	                 pixel_rgb565[10:5],  pixel_rgb565[10:9],
	                 pixel_rgb565[4:0],   pixel_rgb565[4:2]};

	logic                       text_we;
	logic [TEXT_AW-1:0]         text_waddr;
	logic [rtoc_pkg::CODE_W-1:0] text_wdata;
	logic                       text_re;
	logic [rtoc_pkg::CODE_W-1:0] text_rdata;

	// Text writes and pixel reads both happen at request accept, so the
	// memory sees them in request order and no forwarding is needed.
	always_comb begin
		if (clear_busy_q) begin
			text_we    = {1'b0, clr_q} < TEXT_LIMIT;
			text_waddr = clr_q[TEXT_AW-1:0];
			text_wdata = '0;
		end else begin
			text_we    = in_acc && (command == rtoc_pkg::CMD_TEXT_WR)
				&& ({1'b0, store_index} < TEXT_LIMIT);
			text_waddr = store_index[TEXT_AW-1:0];
			text_wdata = store_data[rtoc_pkg::CODE_W-1:0];
		end
	end

	assign text_re = in_acc && (command == rtoc_pkg::CMD_PIXEL);

	rtoc_ram #(
		.WIDTH (rtoc_pkg::CODE_W),
		.DEPTH (TEXT_DEPTH)
	) u_text_ram (
		.clk   (clk),
		.we    (text_we),
		.waddr (text_waddr),
		.wdata (text_wdata),
		.re    (text_re),
		.raddr (pos.tidx[TEXT_AW-1:0]),
		.rdata (text_rdata)
	);

	// Stage 1 registers
	logic [1:0]                   cmd_s1;
	logic                         hit_s1;
	logic                         tidx_ok_s1;
	logic [2:0]                   gx_s1;
	logic [3:0]                   gy_s1;
	logic [23:0]                  rgb_s1;
	logic [rtoc_pkg::FONT_AW-1:0] idx_s1;
	logic [rtoc_pkg::DATA_W-1:0]  data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1     <= command;
			hit_s1     <= pos.hit;
			tidx_ok_s1 <= tidx_ok;
			gx_s1      <= pos.gx;
			gy_s1      <= pos.gy;
			rgb_s1     <= rgb888;
			idx_s1     <= store_index;
			data_s1    <= store_data;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: access font memory
	// ------------------------------------------------------------------
	logic [rtoc_pkg::CODE_W-1:0]  code_s1;
	logic [rtoc_pkg::FONT_AW-1:0] fidx_s1;
	logic                         font_we;
	logic [rtoc_pkg::FONT_AW-1:0] font_waddr;
	logic [rtoc_pkg::DATA_W-1:0]  font_wdata;
	logic                         font_re;
	logic [rtoc_pkg::DATA_W-1:0]  font_rdata;

	assign code_s1 = tidx_ok_s1 ? text_rdata : '0;
	assign fidx_s1 = {code_s1, gy_s1[3:1]};

	// Font writes are taken here, in the same stage as font reads, so the
	// memory again sees its accesses in request order.
	always_comb begin
		if (clear_busy_q) begin
			font_we    = 1'b1;
			font_waddr = clr_q;
			font_wdata = '0;
		end else begin
			font_we    = move1 && (cmd_s1 == rtoc_pkg::CMD_FONT_WR);
			font_waddr = idx_s1;
			font_wdata = data_s1;
		end
	end

	assign font_re = move1 && (cmd_s1 == rtoc_pkg::CMD_PIXEL);

	rtoc_ram #(
		.WIDTH (rtoc_pkg::DATA_W),
		.DEPTH (rtoc_pkg::FONT_DEPTH)
	) u_font_ram (
		.clk   (clk),
		.we    (font_we),
		.waddr (font_waddr),
		.wdata (font_wdata),
		.re    (font_re),
		.raddr (fidx_s1),
		.rdata (font_rdata)
	);

	// Stage 2 registers: pixels only, store requests drop out here
	logic        hit_s2;
	logic [2:0]  gx_s2;
	logic        odd_s2;
	logic [23:0] rgb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1 && (cmd_s1 == rtoc_pkg::CMD_PIXEL);
		end
	end

	always_ff @(posedge clk) begin
		if (font_re) begin
			hit_s2 <= hit_s1;
			gx_s2  <= gx_s1;
			odd_s2 <= gy_s1[0];
			rgb_s2 <= rgb_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: pick the glyph line and bit, compose the result
	// ------------------------------------------------------------------
	logic [7:0]               line_s2;
	logic                     white_s2;
	logic [rtoc_pkg::ARGB_W-1:0] argb_s2;

	// Even lines use the low byte, odd lines the high byte; MSB is leftmost
	assign line_s2  = odd_s2 ? font_rdata[15:8] : font_rdata[7:0];
	assign white_s2 = hit_s2 && line_s2[~gx_s2];
	assign argb_s2  = white_s2 ? rtoc_pkg::ARGB_WHITE : {rtoc_pkg::ALPHA_OPAQUE, rgb_s2};

	// Output register
	logic                        out_valid_q;
	logic [rtoc_pkg::ARGB_W-1:0] argb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (move2) begin
			argb_q <= argb_s2;
		end
	end

	assign out_valid  = out_valid_q;
	assign argb_pixel = argb_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clear_busy_q |-> !valid_s1 && !valid_s2)
		else $error("request in pipeline during clearing pass");

	a_font_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(font_re && font_we))
		else $error("font memory read and write in the same cycle");

	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> valid_s1)
		else $error("accepted request lost before stage 1");

	a_clear_len: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clear_busy_q) |-> $past(clr_q) == rtoc_pkg::FONT_AW'(rtoc_pkg::FONT_DEPTH - 1))
		else $error("clearing pass ended early");

endmodule
